// ----- sv/mblbp_pkg.sv -----
// ----------------------------------------------------------------------------
// mblbp_pkg
// Shared constants, types and tables of the multi-block LBP feature unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mblbp_pkg;

    localparam int WIN_WIDTH  = 24;
    localparam int WIN_HEIGHT = 24;
    localparam int DEPTH      = WIN_WIDTH * WIN_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int SUM_W      = $clog2(DEPTH * 255 + 1);
    localparam int ROWSUM_W   = $clog2(WIN_WIDTH * 255 + 1);
    localparam int COL_W      = $clog2(WIN_WIDTH);
    localparam int ROW_W      = $clog2(WIN_HEIGHT);
    localparam int GRID_W     = 8;
    localparam int BLK_W      = SUM_W + 2;

    localparam logic       MODE_LOAD  = 1'b0;
    localparam logic       MODE_QUERY = 1'b1;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_GRID   = 2'd1;
    localparam logic [1:0] ERR_EMPTY  = 2'd2;

    // outer block order: bit 7 top-left, clockwise to bit 0 middle-left
    localparam logic [1:0] GRID_R [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1};
    localparam logic [1:0] GRID_C [8] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0};

    typedef struct packed {
        logic       is_query;
        logic [7:0] pixel;
        logic [4:0] corner_x;
        logic [4:0] corner_y;
        logic [3:0] block_width;
        logic [3:0] block_height;
        logic       grid_err;
    } req_t;

    typedef logic signed [BLK_W-1:0] blk_t;

endpackage

`default_nettype wire

// ----- sv/mblbp_item_if.sv -----
// ----------------------------------------------------------------------------
// mblbp_item_if
// Request channel: pixel loads and feature queries.
// ----------------------------------------------------------------------------
`default_nettype none

interface mblbp_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] pixel;
    logic [4:0] corner_x;
    logic [4:0] corner_y;
    logic [3:0] block_width;
    logic [3:0] block_height;

    modport source (output valid, mode, pixel, corner_x, corner_y, block_width,
                    block_height, input ready);
    modport sink   (input valid, mode, pixel, corner_x, corner_y, block_width,
                    block_height, output ready);
endinterface

`default_nettype wire

// ----- sv/mblbp_result_if.sv -----
// ----------------------------------------------------------------------------
// mblbp_result_if
// Result channel: LBP code and error status of a query.
// ----------------------------------------------------------------------------
`default_nettype none

interface mblbp_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] lbp_code;
    logic [1:0] error_code;

    modport source (output valid, lbp_code, error_code, input ready);
    modport sink   (input valid, lbp_code, error_code, output ready);
endinterface

`default_nettype wire

// ----- sv/mblbp_ram.sv -----
// ----------------------------------------------------------------------------
// mblbp_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mblbp_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 576
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- sv/mblbp_front.sv -----
// ----------------------------------------------------------------------------
// mblbp_front
// Accepts requests, checks the grid bounds and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mblbp_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    mblbp_item_if.sink           item,
    output logic                 q_valid,
    output mblbp_pkg::req_t      q_req,
    input  wire logic            q_pop
);
    import mblbp_pkg::*;

    req_t             slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic [GRID_W-1:0] span_x, span_y;
    req_t             new_req;

    assign item.ready = (count_reg != 2'd2);
    assign push       = item.valid && item.ready;
    assign q_valid    = (count_reg != 2'd0);
    assign q_req      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        span_x = GRID_W'(item.corner_x) + GRID_W'(2'd3) * GRID_W'(item.block_width);
        span_y = GRID_W'(item.corner_y) + GRID_W'(2'd3) * GRID_W'(item.block_height);
        new_req.is_query     = (item.mode == MODE_QUERY);
        new_req.pixel        = item.pixel;
        new_req.corner_x     = item.corner_x;
        new_req.corner_y     = item.corner_y;
        new_req.block_width  = item.block_width;
        new_req.block_height = item.block_height;
        new_req.grid_err     = (span_x > GRID_W'(WIN_WIDTH)) || (span_y > GRID_W'(WIN_HEIGHT));
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_req;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mblbp_back.sv -----
// ----------------------------------------------------------------------------
// mblbp_back
// Builds the integral image and evaluates queries from sixteen corner reads.
// ----------------------------------------------------------------------------
`default_nettype none

module mblbp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  mblbp_pkg::req_t      q_req,
    output logic                 q_pop,
    mblbp_result_if.source       result
);
    import mblbp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam int         AW2    = ADDR_W + GRID_W;

    logic [2:0]          state_reg, state_next;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [ROWSUM_W-1:0] rowsum_reg;
    logic                loaded_reg;
    logic [SUM_W-1:0]    line_reg [WIN_WIDTH];
    logic [3:0]          cnt_reg;
    logic [GRID_W-1:0]   i_reg, j_reg;
    req_t                cur_reg;
    logic                cap_vld_reg, cap_zero_reg;
    logic [3:0]          cap_idx_reg;
    logic [SUM_W-1:0]    p_reg [16];
    blk_t                blk_reg [8];
    blk_t                centre_reg;
    logic                out_vld_reg;
    logic [7:0]          lbp_reg;
    logic [1:0]          err_reg;

    logic                do_load, do_query;
    logic [ROWSUM_W-1:0] rowsum_new;
    logic [SUM_W-1:0]    above, integ_val;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [SUM_W-1:0]    ram_rdata;
    logic [AW2-1:0]      rd_full, wr_full;
    logic                corner_zero;
    blk_t                blk_sum [8];
    blk_t                centre_sum;
    logic [7:0]          code;

    function automatic blk_t ext(input logic [SUM_W-1:0] v);
        ext = blk_t'({2'b00, v});
    endfunction

    assign q_pop    = q_valid && (state_reg == S_IDLE) && (!q_req.is_query || !out_vld_reg);
    assign do_load  = q_pop && !q_req.is_query;
    assign do_query = q_pop && q_req.is_query && loaded_reg && !q_req.grid_err;

    assign result.valid      = out_vld_reg;
    assign result.lbp_code   = lbp_reg;
    assign result.error_code = err_reg;

    always_comb
    begin
        rowsum_new  = ((col_reg == '0) ? '0 : rowsum_reg) + ROWSUM_W'(q_req.pixel);
        above       = (row_reg == '0) ? '0 : line_reg[0];
        integ_val   = above + SUM_W'(rowsum_new);
        wr_full     = AW2'(row_reg) * AW2'(WIN_WIDTH) + AW2'(col_reg);
        rd_full     = (AW2'(i_reg) - AW2'(1)) * AW2'(WIN_WIDTH) + AW2'(j_reg) - AW2'(1);
        corner_zero = (i_reg == '0) || (j_reg == '0);
        ram_we      = do_load;
        ram_addr    = (state_reg == S_READ) ? rd_full[ADDR_W-1:0] : wr_full[ADDR_W-1:0];
    end

    mblbp_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (integ_val),
        .rdata (ram_rdata)
    );

    // nine block sums from the 4x4 corner grid
    always_comb
    begin
        centre_sum = ext(p_reg[10]) - ext(p_reg[9]) - ext(p_reg[6]) + ext(p_reg[5]);
        for (int k = 0; k < 8; k++)
        begin
            blk_sum[k] = ext(p_reg[(int'(GRID_R[k]) + 1) * 4 + int'(GRID_C[k]) + 1])
                       - ext(p_reg[(int'(GRID_R[k]) + 1) * 4 + int'(GRID_C[k])])
                       - ext(p_reg[int'(GRID_R[k]) * 4 + int'(GRID_C[k]) + 1])
                       + ext(p_reg[int'(GRID_R[k]) * 4 + int'(GRID_C[k])]);
        end
        for (int k = 0; k < 8; k++)
        begin
            code[7 - k] = (blk_reg[k] >= centre_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = do_query ? S_READ : S_IDLE;
            S_READ:  state_next = (cnt_reg == 4'd15) ? S_LAST : S_READ;
            S_LAST:  state_next = S_SUM;
            S_SUM:   state_next = S_CMP;
            S_CMP:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            rowsum_reg  <= '0;
            loaded_reg  <= 1'b0;
            cap_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cap_vld_reg <= (state_reg == S_READ);
            if (do_load)
            begin
                rowsum_reg <= rowsum_new;
                loaded_reg <= 1'b0;
                if (col_reg == COL_W'(WIN_WIDTH - 1))
                begin
                    col_reg <= '0;
                    if (row_reg == ROW_W'(WIN_HEIGHT - 1))
                    begin
                        row_reg    <= '0;
                        loaded_reg <= 1'b1;
                    end
                    else
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (out_vld_reg && result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            else if (q_pop && q_req.is_query && !do_query)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (state_reg == S_CMP)
            begin
                out_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // previous row of integral values, column 0 at the head
        if (do_load)
        begin
            for (int k = 0; k < WIN_WIDTH - 1; k++)
            begin
                line_reg[k] <= line_reg[k + 1];
            end
            line_reg[WIN_WIDTH - 1] <= integ_val;
        end
        if (do_query)
        begin
            cur_reg <= q_req;
            cnt_reg <= '0;
            i_reg   <= GRID_W'(q_req.corner_y);
            j_reg   <= GRID_W'(q_req.corner_x);
        end
        else if (state_reg == S_READ)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg[1:0] == 2'd3)
            begin
                j_reg <= GRID_W'(cur_reg.corner_x);
                i_reg <= i_reg + GRID_W'(cur_reg.block_height);
            end
            else
            begin
                j_reg <= j_reg + GRID_W'(cur_reg.block_width);
            end
        end
        cap_idx_reg  <= cnt_reg;
        cap_zero_reg <= corner_zero;
        if (cap_vld_reg)
        begin
            p_reg[cap_idx_reg] <= cap_zero_reg ? '0 : ram_rdata;
        end
        if (state_reg == S_SUM)
        begin
            blk_reg    <= blk_sum;
            centre_reg <= centre_sum;
        end
        if (q_pop && q_req.is_query && !do_query)
        begin
            lbp_reg <= 8'd0;
            err_reg <= loaded_reg ? ERR_GRID : ERR_EMPTY;
        end
        else if (state_reg == S_CMP)
        begin
            lbp_reg <= code;
            err_reg <= ERR_NONE;
        end
    end

    a_cmp_emits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |=> out_vld_reg)
        else $error("query result not presented after compare");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_IDLE)
        else $error("store written during a query");

    a_loaded_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(loaded_reg) |-> $past(do_load))
        else $error("window flag dropped without a pixel load");

    a_query_slot: assert property (@(posedge clk) disable iff (!rst_n)
        do_query |-> !out_vld_reg)
        else $error("query started with result slot busy");

endmodule

`default_nettype wire

// ----- sv/multiblock_lbp_feature.sv -----
// ----------------------------------------------------------------------------
// multiblock_lbp_feature
// 3x3 multi-block LBP unit: integral image build and feature queries.
// ----------------------------------------------------------------------------
// Pixel load: written to the store as it leaves the queue; loads sustain
// one per cycle while no query is in progress. Query: queue head to result
// via 16 single-port store reads, one read flush, one block-sum stage, one
// compare stage. Rejected queries give a result in the cycle after the pop.
// Reset clears control state; the integral store holds no reset value.
`default_nettype none

module multiblock_lbp_feature (
    input  wire logic      clk,
    input  wire logic      rst_n,
    mblbp_item_if.sink     item,
    mblbp_result_if.source result
);
    import mblbp_pkg::*;

    logic q_valid;
    req_t q_req;
    logic q_pop;

    mblbp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop)
    );

    mblbp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// ----- test/multiblock_lbp_feature_tb.sv -----
// ----------------------------------------------------------------------------
// multiblock_lbp_feature_tb
// Loads detection windows, sends feature queries and checks each LBP code and
// error status against a behavioral integral-image predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module multiblock_lbp_feature_tb;
    import mblbp_pkg::*;

    logic clk;
    logic rst_n;

    mblbp_item_if   item ();
    mblbp_result_if result ();

    multiblock_lbp_feature DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    typedef struct packed {
        logic [7:0] lbp_code;
        logic [1:0] error_code;
    } lbp_res_t;

    // predictor state
    int unsigned integral_img [DEPTH];
    int          next_col;
    int          next_row;
    int unsigned row_sum;
    bit          win_full;

    lbp_res_t    expected_q [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  errors;
    int  queries_sent;
    int  pixels_sent;
    int  codes_checked;
    longint cycles;

    localparam longint CYCLE_LIMIT = 2000000;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic int unsigned corner_sum(int i, int j);
        if (i == 0 || j == 0 || i > WIN_HEIGHT || j > WIN_WIDTH)
            return 0;
        return integral_img[(i - 1) * WIN_WIDTH + (j - 1)];
    endfunction

    // advance the integral image by one pixel
    function automatic void integrate_pixel(logic [7:0] pix);
        int unsigned above;
        above = 0;
        if (win_full)
            win_full = 1'b0;
        row_sum = (next_col == 0 ? 0 : row_sum) + pix;
        if (next_row != 0)
            above = integral_img[(next_row - 1) * WIN_WIDTH + next_col];
        integral_img[next_row * WIN_WIDTH + next_col] = above + row_sum;
        next_col++;
        if (next_col == WIN_WIDTH)
        begin
            next_col = 0;
            next_row++;
            if (next_row == WIN_HEIGHT)
            begin
                next_row = 0;
                win_full = 1'b1;
            end
        end
    endfunction

    function automatic lbp_res_t lbp_of_query(int x, int y, int w, int h);
        lbp_res_t r;
        int       p [4][4];
        int       centre;
        int       s;
        int       br;
        int       bc;
        r = '0;
        if (!win_full)
        begin
            r.error_code = ERR_EMPTY;
            return r;
        end
        if (x + 3 * w > WIN_WIDTH || y + 3 * h > WIN_HEIGHT)
        begin
            r.error_code = ERR_GRID;
            return r;
        end
        for (int a = 0; a < 4; a++)
            for (int b = 0; b < 4; b++)
                p[a][b] = int'(corner_sum(y + a * h, x + b * w));
        centre = p[2][2] - p[2][1] - p[1][2] + p[1][1];
        for (int k = 0; k < 8; k++)
        begin
            br = int'(GRID_R[k]);
            bc = int'(GRID_C[k]);
            s = p[br + 1][bc + 1] - p[br + 1][bc] - p[br][bc + 1] + p[br][bc];
            if (s >= centre)
                r.lbp_code[7 - k] = 1'b1;
        end
        r.error_code = ERR_NONE;
        return r;
    endfunction

    task automatic send_request(logic md, logic [7:0] pix, logic [4:0] x, logic [4:0] y,
                                logic [3:0] w, logic [3:0] h);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            item.valid <= 1'b0;
            @(negedge clk);
        end
        item.valid        <= 1'b1;
        item.mode         <= md;
        item.pixel        <= pix;
        item.corner_x     <= x;
        item.corner_y     <= y;
        item.block_width  <= w;
        item.block_height <= h;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        if (md == MODE_LOAD)
        begin
            integrate_pixel(pix);
            pixels_sent++;
        end
        else
        begin
            expected_q.push_back(lbp_of_query(x, y, w, h));
            queries_sent++;
        end
        @(negedge clk);
    endtask

    task automatic send_pixel(logic [7:0] pix);
        send_request(MODE_LOAD, pix, 5'($urandom), 5'($urandom), 4'($urandom),
                     4'($urandom));
    endtask

    task automatic send_query(int x, int y, int w, int h);
        send_request(MODE_QUERY, 8'($urandom), x[4:0], y[4:0], w[3:0], h[3:0]);
    endtask

    // one window of flat 255, flat 0 or random content, chosen by flavor
    task automatic load_window(int flavor);
        for (int n = 0; n < DEPTH; n++)
        begin
            case (flavor)
                0: send_pixel(8'd255);
                1: send_pixel(8'd0);
                default: send_pixel(8'($urandom));
            endcase
        end
    endtask

    task automatic random_query();
        int w;
        int h;
        w = $urandom_range(8, 1);
        h = $urandom_range(8, 1);
        if ($urandom_range(9) < 8)
            send_query($urandom_range(WIN_WIDTH - 3 * w), $urandom_range(WIN_HEIGHT - 3 * h),
                       w, h);
        else
            send_query($urandom_range(31), $urandom_range(31), $urandom_range(15),
                       $urandom_range(15));
    endtask

    task automatic drain();
        item.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // result checker
    initial
    begin
        lbp_res_t want;
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result code=%0h err=%0d", result.lbp_code,
                           result.error_code);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    codes_checked++;
                    if (result.lbp_code !== want.lbp_code)
                    begin
                        $error("lbp_code expected %0h actual %0h", want.lbp_code,
                               result.lbp_code);
                        errors++;
                    end
                    if (result.error_code !== want.error_code)
                    begin
                        $error("error_code expected %0d actual %0d", want.error_code,
                               result.error_code);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver stall
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                result.ready <= 1'b0;
            else if (recv_stall_pct > 0)
                result.ready <= ($urandom_range(99) >= recv_stall_pct);
            else
                result.ready <= 1'b1;
        end
    end

    task automatic test_empty_window();
        send_query(0, 0, 1, 1);
        send_query(23, 23, 8, 8);
        for (int n = 0; n < 30; n++)
            send_pixel(8'($urandom));
        send_query(0, 0, 2, 2);
        drain();
    endtask

    task automatic test_directed_queries();
        // complete the partial window left behind with random content
        while (!(next_col == 0 && next_row == 0))
            send_pixel(8'($urandom));
        send_query(0, 0, 8, 8);
        send_query(21, 21, 1, 1);
        send_query(22, 0, 1, 1);
        send_query(0, 22, 1, 1);
        send_query(31, 31, 15, 15);
        send_query(0, 0, 0, 3);
        send_query(5, 2, 4, 0);
        send_query(10, 10, 4, 4);
        drain();
    endtask

    task automatic test_random_phase(int idle, int stall, int nq);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int q = 0; q < nq; q++)
            random_query();
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int q = 0; q < 60; q++)
                random_query();
        join
        drain();
    endtask

    task automatic test_flat_window();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_window(0);
        send_query(0, 0, 8, 8);
        send_query(0, 0, 0, 0);
        send_query(23, 23, 0, 5);
        send_query(16, 16, 15, 15);
        drain();
        send_pixel(8'd7);
        send_query(0, 0, 1, 1);
        drain();
    endtask

    initial
    begin
        errors = 0; queries_sent = 0; pixels_sent = 0; codes_checked = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
        next_col = 0; next_row = 0; row_sum = 0; win_full = 1'b0;
        foreach (integral_img[k])
            integral_img[k] = 0;
        item.valid = 1'b0; item.mode = MODE_LOAD; item.pixel = '0;
        item.corner_x = '0; item.corner_y = '0;
        item.block_width = '0; item.block_height = '0;
        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_window();
        test_directed_queries();
        test_random_phase(0, 0, 80);
        test_backpressure();
        test_random_phase(51, 0, 80);
        test_random_phase(0, 51, 80);
        test_random_phase(13, 13, 80);
        test_flat_window();

        $display("covered %0d pixel loads and %0d queries, %0d results checked",
                 pixels_sent, queries_sent, codes_checked);
        $display("incl. empty window, grid overflow, zero blocks and held-off output");
        if (errors == 0 && expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire

// ----- filelist.f -----
sv/mblbp_pkg.sv
sv/mblbp_item_if.sv
sv/mblbp_result_if.sv
sv/mblbp_ram.sv
sv/mblbp_front.sv
sv/mblbp_back.sv
sv/multiblock_lbp_feature.sv
test/multiblock_lbp_feature_tb.sv
